// ===== rtl/core/mfmssd_pkg.sv =====
// ----------------------------------------------------------------------------
// MFM sync search decoder package
// Request and response types, command and status codes, register indexes.
// ----------------------------------------------------------------------------
package mfmssd_pkg;

   localparam int WORD_W  = 16;
   localparam int SHIFT_W = 5;
   localparam int COUNT_W = 13;
   localparam int BYTE_W  = 8;

   typedef enum logic [1:0] {
      CMD_ARM     = 2'd0,
      CMD_WORD    = 2'd1,
      CMD_TIMEOUT = 2'd2,
      CMD_UNUSED  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_DATA    = 2'd0,
      STATUS_SYNC    = 2'd1,
      STATUS_NOSYNC  = 2'd2,
      STATUS_TIMEOUT = 2'd3
   } status_type;

   localparam logic [1:0] CSR_SYNC_PATTERN     = 2'd0;
   localparam logic [1:0] CSR_MAX_SEARCH_WORDS = 2'd1;
   localparam logic [1:0] CSR_DECODE_LENGTH    = 2'd2;

   localparam logic [WORD_W-1:0]  SYNC_PATTERN_RESET     = 16'h4489;
   localparam logic [WORD_W-1:0]  MAX_SEARCH_WORDS_RESET = 16'd64;
   localparam logic [COUNT_W-1:0] DECODE_LENGTH_RESET    = 13'd512;

   typedef struct packed {
      logic [1:0]        cmd;
      logic [WORD_W-1:0] raw_word;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic [BYTE_W-1:0]  data_byte;
      logic [SHIFT_W-1:0] bit_shift;
      logic [COUNT_W-1:0] byte_count;
      logic               last_of_run;
   } rsp_type;

endpackage

// ===== rtl/core/mfm_sync_search_decoder_core.sv =====
// ----------------------------------------------------------------------------
// MFM sync search decoder core
// Takes one request per clock cycle, at full rate, whenever the response
// register is empty or is being emptied in the same cycle. Each request is
// handled combinationally: the seventeen sync compares, the realignment and
// the even-bit extraction sit between the run state registers and the response
// register, so a response appears on the cycle after its request and is held
// there until it is taken. Arming resets the run; the search and decode
// phases then follow the raw words, and a timeout closes any active run.
// ----------------------------------------------------------------------------
module mfm_sync_search_decoder_core #(
   parameter int MAX_RUN_BYTES = 4096
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  mfmssd_pkg::req_type       req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output mfmssd_pkg::rsp_type       rsp_payload,
   input  logic                      csr_write_enable,
   input  logic [1:0]                csr_index,
   input  logic [15:0]               csr_write_data
);

   localparam logic [15:0] MaxRun = 16'(MAX_RUN_BYTES);

   typedef enum logic [3:0] {
      PH_IDLE   = 4'b0001,
      PH_FIRST  = 4'b0010,
      PH_SEARCH = 4'b0100,
      PH_DECODE = 4'b1000
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [15:0] older_ff, older_in;
   logic [15:0] tested_ff, tested_in;
   logic [4:0]  shift_ff, shift_in;
   logic [15:0] carry_ff, carry_in;
   logic [12:0] done_ff, done_in;

   logic [15:0] pattern_ff;
   logic [15:0] max_search_ff;
   logic [12:0] length_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   mfmssd_pkg::rsp_type  rsp_ff, rsp_in;

   logic        accept;
   logic        emit;
   logic [31:0] window;
   logic        found;
   logic [4:0]  found_shift;
   logic [4:0]  carry_shift;
   logic [31:0] carry_wide;
   logic [15:0] realigned;
   logic [7:0]  even_bits;
   logic [12:0] done_next;
   logic [15:0] run_len;

   assign req_ready   = !rsp_valid_ff || rsp_ready;
   assign accept      = req_valid && req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assign window = {older_ff, req_payload.raw_word};

   always_comb begin
      found       = 1'b0;
      found_shift = '0;
      for (int sh = 16; sh >= 0; sh--) begin
         if (window[sh +: 16] == pattern_ff) begin
            found       = 1'b1;
            found_shift = 5'(sh);
         end
      end
   end

   // Leftover low bits of the new word, left aligned; none at shift zero.
   assign carry_shift = phase_ff == PH_DECODE ? shift_ff : found_shift;
   assign carry_wide  = {16'b0, req_payload.raw_word} << (5'd16 - carry_shift);
   assign realigned   = carry_ff | (req_payload.raw_word >> shift_ff);

   always_comb begin
      for (int k = 0; k < 8; k++) begin
         even_bits[k] = realigned[2 * k];
      end
   end

   assign done_next = done_ff + 13'd1;
   assign run_len   = ({3'b0, length_ff} < MaxRun) ? {3'b0, length_ff} : MaxRun;

   always_comb begin
      phase_in  = phase_ff;
      older_in  = older_ff;
      tested_in = tested_ff;
      shift_in  = shift_ff;
      carry_in  = carry_ff;
      done_in   = done_ff;
      emit      = 1'b0;
      rsp_in    = rsp_ff;
      case (req_payload.cmd)
         mfmssd_pkg::CMD_ARM: begin
            phase_in  = PH_FIRST;
            older_in  = '0;
            tested_in = '0;
            shift_in  = '0;
            carry_in  = '0;
            done_in   = '0;
         end
         mfmssd_pkg::CMD_TIMEOUT: begin
            if (phase_ff != PH_IDLE) begin
               emit                = 1'b1;
               rsp_in.status       = mfmssd_pkg::STATUS_TIMEOUT;
               rsp_in.data_byte    = '0;
               rsp_in.bit_shift    = phase_ff == PH_DECODE ? shift_ff : '0;
               rsp_in.byte_count   = done_ff;
               rsp_in.last_of_run  = 1'b1;
               phase_in            = PH_IDLE;
            end
         end
         mfmssd_pkg::CMD_WORD: begin
            case (phase_ff)
               PH_FIRST: begin
                  older_in = req_payload.raw_word;
                  phase_in = PH_SEARCH;
               end
               PH_SEARCH: begin
                  if (tested_ff >= max_search_ff) begin
                     emit               = 1'b1;
                     rsp_in.status      = mfmssd_pkg::STATUS_NOSYNC;
                     rsp_in.data_byte   = '0;
                     rsp_in.bit_shift   = '0;
                     rsp_in.byte_count  = '0;
                     rsp_in.last_of_run = 1'b1;
                     phase_in           = PH_IDLE;
                  end else if (found) begin
                     emit               = 1'b1;
                     shift_in           = found_shift;
                     carry_in           = carry_wide[15:0];
                     done_in            = '0;
                     rsp_in.status      = mfmssd_pkg::STATUS_SYNC;
                     rsp_in.data_byte   = '0;
                     rsp_in.bit_shift   = found_shift;
                     rsp_in.byte_count  = '0;
                     rsp_in.last_of_run = run_len == '0;
                     phase_in           = run_len == '0 ? PH_IDLE : PH_DECODE;
                  end else begin
                     older_in  = req_payload.raw_word;
                     tested_in = tested_ff + 16'd1;
                  end
               end
               PH_DECODE: begin
                  emit               = 1'b1;
                  carry_in           = carry_wide[15:0];
                  done_in            = done_next;
                  rsp_in.status      = mfmssd_pkg::STATUS_DATA;
                  rsp_in.data_byte   = even_bits;
                  rsp_in.bit_shift   = shift_ff;
                  rsp_in.byte_count  = done_next;
                  rsp_in.last_of_run = {3'b0, done_next} >= run_len;
                  if ({3'b0, done_next} >= run_len) begin
                     phase_in = PH_IDLE;
                  end
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end
         default: begin
            phase_in = phase_ff;
         end
      endcase
   end

   always_comb begin
      if (accept && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         older_ff     <= '0;
         tested_ff    <= '0;
         shift_ff     <= '0;
         carry_ff     <= '0;
         done_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff  <= phase_in;
            older_ff  <= older_in;
            tested_ff <= tested_in;
            shift_ff  <= shift_in;
            carry_ff  <= carry_in;
            done_ff   <= done_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && emit) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff    <= mfmssd_pkg::SYNC_PATTERN_RESET;
         max_search_ff <= mfmssd_pkg::MAX_SEARCH_WORDS_RESET;
         length_ff     <= mfmssd_pkg::DECODE_LENGTH_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            mfmssd_pkg::CSR_SYNC_PATTERN: begin
               pattern_ff <= csr_write_data;
            end
            mfmssd_pkg::CSR_MAX_SEARCH_WORDS: begin
               max_search_ff <= csr_write_data;
            end
            mfmssd_pkg::CSR_DECODE_LENGTH: begin
               length_ff <= csr_write_data[12:0];
            end
            default: begin
               length_ff <= length_ff;
            end
         endcase
      end
   end

endmodule

// ===== rtl/core/mfmssd_checker.sv =====
// ----------------------------------------------------------------------------
// MFM sync search decoder checker
// Port-level properties of the response stream, bound to the core.
// ----------------------------------------------------------------------------
module mfmssd_checker (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input mfmssd_pkg::rsp_type rsp_payload
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("A stalled response changed or was dropped.");

   a_byte_only_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != mfmssd_pkg::STATUS_DATA
         |-> rsp_payload.data_byte == 8'd0)
      else $error("A status response carries a data byte.");

   a_end_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.status == mfmssd_pkg::STATUS_NOSYNC ||
                    rsp_payload.status == mfmssd_pkg::STATUS_TIMEOUT)
         |-> rsp_payload.last_of_run)
      else $error("A run-ending response is not marked last.");

   a_sync_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == mfmssd_pkg::STATUS_SYNC
         |-> rsp_payload.byte_count == 13'd0 && rsp_payload.bit_shift <= 5'd16)
      else $error("A sync response has a byte count or an impossible shift.");

endmodule

bind mfm_sync_search_decoder_core mfmssd_checker u_mfmssd_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);
